>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_ALWAYS(lbl, expr)
`define AST_IMPLY(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants shared by the custom-alphabet decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int MAX_BYTES_DEF   = 128;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [31:0] SEED_RST      = 32'hC396A5E7;
  localparam logic [7:0]  MIN_BYTES_RST = 8'd37;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BYTES = 2'd1;

  localparam logic [7:0] CH_LO_A   = 8'h23;
  localparam logic [7:0] CH_HI_A   = 8'h5B;
  localparam logic [7:0] CH_LO_B   = 8'h5D;
  localparam logic [7:0] CH_HI_B   = 8'h63;
  localparam logic [5:0] SEXT_OFS_B = 6'd57;

  localparam int ROT = 7;
  localparam logic [7:0] SUM_BYTES = 8'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADCHAR  = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_SHORT    = 3'd3,
    ST_LONG     = 3'd4,
    ST_CHECKSUM = 3'd5
  } status_t;

  typedef struct packed {
    logic [31:0] seed;
    logic [7:0]  min_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [6:0] index;
    logic       eot;
    status_t    status;
  } result_t;

  typedef struct packed {
    result_t [2:0] slot;
    logic [1:0]    n;
  } bundle_t;

endpackage

>>> rtl/core/b64d_decode.sv
// ----------------------------------------------------------------------------
// b64d_decode
// Per-character decode: sextet map, byte unchaining, checksum fold and
// end-of-text status. Produces up to three results per accepted character.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_decode #(
  parameter int MAX_BYTES = b64d_pkg::MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  input  b64d_pkg::cfg_t    cfg,
  output b64d_pkg::bundle_t bundle
);
  import b64d_pkg::*;

  localparam logic [7:0] CAP = 8'(MAX_BYTES);

  typedef struct packed {
    logic [7:0]  prev;
    logic [7:0]  seen;
    logic [31:0] exp_sum;
    logic [31:0] run_sum;
    status_t     err;
  } chain_t;

  typedef struct packed {
    chain_t  s;
    logic    emit;
    result_t r;
  } step_t;

  function automatic step_t take_byte(chain_t s, logic [7:0] chained, logic [31:0] seed);
    step_t       o;
    logic [7:0]  plain;
    logic [31:0] base;
    o       = '0;
    o.s     = s;
    plain   = chained ^ s.prev;
    base    = (s.seen == SUM_BYTES) ? seed : s.run_sum;
    if (s.err == ST_OK) begin
      if (s.seen >= CAP) begin
        o.s.err = ST_LONG;
      end else begin
        o.s.prev = chained;
        o.s.seen = s.seen + 8'd1;
        if (s.seen < SUM_BYTES) begin
          o.s.exp_sum = {s.exp_sum[23:0], plain};
        end else begin
          o.s.run_sum = {base[31-ROT:0], base[31:32-ROT]} ^ {24'd0, plain};
          o.r.data    = plain;
          o.r.valid   = 1'b1;
          o.r.index   = s.seen[6:0];
          o.r.eot     = 1'b0;
          o.r.status  = ST_OK;
          o.emit      = 1'b1;
        end
      end
    end
    return o;
  endfunction

  chain_t      chain_r, chain_nxt;
  logic [17:0] store_r, store_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  step_t       t0, t1, t2;
  logic [5:0]  sext;
  logic        bad;
  logic [23:0] word;
  logic [31:0] actual;
  status_t     st;
  bundle_t     bun;
  chain_t      cur;
  logic        closing;

  assign closing = accept && last_char;

  always_comb begin
    bad  = 1'b0;
    sext = '0;
    if (char_code inside {[CH_LO_A:CH_HI_A]}) begin
      sext = 6'(char_code - CH_LO_A);
    end else if (char_code inside {[CH_LO_B:CH_HI_B]}) begin
      sext = 6'(char_code - CH_LO_B) + SEXT_OFS_B;
    end else begin
      bad = 1'b1;
    end
  end

  always_comb begin
    cur       = chain_r;
    store_nxt = store_r;
    cnt_nxt   = cnt_r;
    bun       = '0;
    word      = {store_r, sext};
    t0        = '0;
    t1        = '0;
    t2        = '0;
    actual    = '0;
    st        = ST_OK;
    if (chain_r.err == ST_OK) begin
      if (bad) begin
        cur.err = ST_BADCHAR;
      end else if (cnt_r != 2'd3) begin
        store_nxt = {store_r[11:0], sext};
        cnt_nxt   = cnt_r + 2'd1;
      end else begin
        store_nxt = '0;
        cnt_nxt   = '0;
        t0  = take_byte(chain_r, word[23:16], cfg.seed);
        t1  = take_byte(t0.s, word[15:8], cfg.seed);
        t2  = take_byte(t1.s, word[7:0], cfg.seed);
        cur = t2.s;
        if (t0.emit) begin
          bun.slot[0] = t0.r;
          bun.slot[1] = t1.r;
          bun.slot[2] = t2.r;
        end else if (t1.emit) begin
          bun.slot[0] = t1.r;
          bun.slot[1] = t2.r;
        end else begin
          bun.slot[0] = t2.r;
        end
        bun.n = {1'b0, t0.emit} + {1'b0, t1.emit} + {1'b0, t2.emit};
      end
    end
    chain_nxt = cur;
    if (last_char) begin
      actual = (cur.seen == SUM_BYTES) ? cfg.seed : cur.run_sum;
      if (cur.err != ST_OK) begin
        st = cur.err;
      end else if (cnt_nxt != 2'd0) begin
        st = ST_LENGTH;
      end else if (cur.seen < cfg.min_bytes || cur.seen < SUM_BYTES) begin
        st = ST_SHORT;
      end else if (actual != cur.exp_sum) begin
        st = ST_CHECKSUM;
      end else begin
        st = ST_OK;
      end
      case (bun.n)
        2'd1: begin
          bun.slot[0].eot    = 1'b1;
          bun.slot[0].status = st;
        end
        2'd2: begin
          bun.slot[1].eot    = 1'b1;
          bun.slot[1].status = st;
        end
        2'd3: begin
          bun.slot[2].eot    = 1'b1;
          bun.slot[2].status = st;
        end
        default: begin
          bun.slot[0].eot    = 1'b1;
          bun.slot[0].status = st;
          bun.n              = 2'd1;
        end
      endcase
      chain_nxt         = '0;
      chain_nxt.run_sum = cfg.seed;
      chain_nxt.err     = ST_OK;
      store_nxt         = '0;
      cnt_nxt           = '0;
    end
  end

  always_comb begin
    bundle = bun;
    if (!accept) begin
      bundle.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '{prev: '0, seen: '0, exp_sum: '0, run_sum: SEED_RST, err: ST_OK};
      store_r <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      chain_r <= chain_nxt;
      store_r <= store_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `AST_NEXT(a_err_sticky, chain_r.err != ST_OK && !closing, chain_r.err == $past(chain_r.err))
  `AST_NEXT(a_clear_after_last, closing, cnt_r == 2'd0 && chain_r.seen == 8'd0 && chain_r.err == ST_OK)
  `AST_ALWAYS(a_seen_cap, chain_r.seen <= CAP)

endmodule

>>> rtl/core/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Result queue: takes up to three results per cycle, hands out one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_fifo #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  b64d_pkg::bundle_t wr,
  input  logic              pop,
  output b64d_pkg::result_t head,
  output logic              nonempty,
  output logic              room
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] wrap(logic [PW-1:0] ptr, logic [1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, ptr} + (PW+1)'(off);
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  result_t        mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign head     = mem[rd_ptr_r];
  assign nonempty = (cnt_r != '0);
  assign room     = (cnt_r <= CW'(DEPTH - 3));

  always_comb begin
    wr_ptr_nxt = wrap(wr_ptr_r, wr.n);
    rd_ptr_nxt = pop ? wrap(rd_ptr_r, 2'd1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(wr.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < wr.n) begin
        mem[wrap(wr_ptr_r, 2'(i))] <= wr.slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `AST_ALWAYS(a_cnt_bound, cnt_r <= CW'(DEPTH))
  `AST_IMPLY(a_no_overflow, wr.n != 2'd0, cnt_r <= CW'(DEPTH - 3))
  `AST_IMPLY(a_no_underflow, pop, cnt_r != '0)

endmodule

>>> rtl/core/base64_variant_unchain_checksum_decoder.sv
// ----------------------------------------------------------------------------
// base64_variant_unchain_checksum_decoder
// Custom-alphabet base64 decoder with XOR unchaining and rotate-xor checksum.
//
//   channel  dir  handshake        payload
//   in_      in   valid / stall    char_code, last_char
//   out_     out  valid / stall    data_byte, byte_valid, byte_index,
//                                  end_of_text, status
//   cfg_     in   valid / ready    index, data (seed, min_bytes)
//
// One character is accepted per cycle while in_stall is low; its results are written
// to the result queue at the accepting edge and leave it in order, one per cycle
// while out_stall is low. A fourth character yields up to three results, so output
// drain sets the rate when the queue has fewer than three free slots (in_stall).
// Reset is synchronous and needs no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
module base64_variant_unchain_checksum_decoder #(
  parameter int MAX_BYTES   = b64d_pkg::MAX_BYTES_DEF,
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_code,
  input  logic                           in_last_char,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_data_byte,
  output logic                           out_byte_valid,
  output logic [6:0]                     out_byte_index,
  output logic                           out_end_of_text,
  output logic [2:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [b64d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import b64d_pkg::*;

  cfg_t    cfg_r;
  bundle_t bundle;
  result_t head;
  logic    accept;
  logic    pop;
  logic    room;
  logic    nonempty;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room;
  assign accept    = in_valid && !in_stall;
  assign out_valid = nonempty;
  assign pop       = nonempty && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{seed: SEED_RST, min_bytes: MIN_BYTES_RST};
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEED:      cfg_r.seed      <= cfg_data;
        CFG_MIN_BYTES: cfg_r.min_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  b64d_decode #(
    .MAX_BYTES (MAX_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .cfg       (cfg_r),
    .bundle    (bundle)
  );

  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (bundle),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .room     (room)
  );

  assign out_data_byte   = head.data;
  assign out_byte_valid  = head.valid;
  assign out_byte_index  = head.index;
  assign out_end_of_text = head.eot;
  assign out_status      = head.status;

endmodule
